// File: sv/bmc_pkg.sv
// Package for the bond Mohr-Coulomb break test.
// Holds configuration layout, register indexes and result codes; no dependencies.
package bmc_pkg;

  localparam int STRESS_WIDTH_DEF = 32;
  localparam int SCALE2 = 102;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_COHESION = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TENSILE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRICTION_TAN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_SIN = 3'd4;

  localparam logic [1:0] FAIL_NONE = 2'd0;
  localparam logic [1:0] FAIL_SHEAR = 2'd1;
  localparam logic [1:0] FAIL_TENSION = 2'd2;

  localparam logic [16:0] PLANE_SIN_RESET = 17'd65536;

  typedef struct packed {
    logic [30:0]        cohesion;
    logic signed [31:0] tensile_strength;
    logic [19:0]        friction_tangent;
    logic signed [16:0] plane_cosine;
    logic [16:0]        plane_sine;
  } cfg_t;

endpackage

// File: sv/bmc_front.sv
// Front pipeline: heavy/light weighting, sum and difference terms, and the
// sum of squares that feeds the square root. Uses bmc_pkg for the default width.
module bmc_front #(
  parameter int W = bmc_pkg::STRESS_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] own_sxx,
  input  logic signed [W-1:0] own_syy,
  input  logic signed [W-1:0] own_sxy,
  input  logic signed [W-1:0] nbr_sxx,
  input  logic signed [W-1:0] nbr_syy,
  input  logic signed [W-1:0] nbr_sxy,
  input  logic                skip,
  input  logic                intact,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2*W+14:0]     out_q,
  output logic [W+9:0]        out_tag
);

  localparam int NST = 7;
  localparam int XW = W + 7;
  localparam int SW = W + 8;
  localparam int MW = W + 7;
  localparam int LO = (MW + 1) / 2;
  localparam int HI = MW - LO;
  localparam int PW = 2 * LO;
  localparam int QW = 2 * MW + 1;

  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;
  logic [NST-1:0] skip_r;
  logic [NST-1:0] int_r;

  logic signed [W-1:0] o0_r [3];
  logic signed [W-1:0] n0_r [3];
  logic signed [W-1:0] h1_r [3];
  logic signed [W-1:0] l1_r [3];
  logic signed [XW-1:0] x2_r, y2_r, z2_r;
  logic signed [SW-1:0] s3_r, d3_r, t3_r;
  logic signed [SW-1:0] s4_r, s5_r, s6_r;
  logic [MW-1:0] md4_r, mt4_r;
  logic [PW-1:0] dhh5_r, dhl5_r, dll5_r, thh5_r, thl5_r, tll5_r;
  logic [QW-1:0] q6_r;

  logic [W-1:0] ao [3];
  logic [W-1:0] an [3];
  logic [W:0] own_mag, nbr_mag;
  logic own_heavy;
  logic signed [XW-1:0] x_nxt, y_nxt, z_nxt;
  logic [HI-1:0] dh, th;
  logic [LO-1:0] dl, tl;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];
  assign out_valid = v_r[NST-1];
  assign out_q = q6_r;
  assign out_tag = {skip_r[NST-1], int_r[NST-1], s6_r};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ao[k] = o0_r[k][W-1] ? W'(-o0_r[k]) : W'(o0_r[k]);
      an[k] = n0_r[k][W-1] ? W'(-n0_r[k]) : W'(n0_r[k]);
    end
    own_mag = (W+1)'(ao[0]) + (W+1)'(ao[1]);
    nbr_mag = (W+1)'(an[0]) + (W+1)'(an[1]);
    own_heavy = own_mag > nbr_mag;
    x_nxt = (XW'(h1_r[0]) <<< 5) + (XW'(h1_r[0]) <<< 4) + (XW'(h1_r[0]) <<< 1)
            + XW'(l1_r[0]);
    y_nxt = (XW'(h1_r[1]) <<< 5) + (XW'(h1_r[1]) <<< 4) + (XW'(h1_r[1]) <<< 1)
            + XW'(l1_r[1]);
    z_nxt = (XW'(h1_r[2]) <<< 5) + (XW'(h1_r[2]) <<< 4) + (XW'(h1_r[2]) <<< 1)
            + XW'(l1_r[2]);
    dh = md4_r[MW-1:LO];
    dl = md4_r[LO-1:0];
    th = mt4_r[MW-1:LO];
    tl = mt4_r[LO-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      o0_r[0] <= own_sxx;
      o0_r[1] <= own_syy;
      o0_r[2] <= own_sxy;
      n0_r[0] <= nbr_sxx;
      n0_r[1] <= nbr_syy;
      n0_r[2] <= nbr_sxy;
      skip_r[0] <= skip;
      int_r[0] <= intact;
    end
    if (adv[1]) begin
      for (int k = 0; k < 3; k++) begin
        h1_r[k] <= own_heavy ? o0_r[k] : n0_r[k];
        l1_r[k] <= own_heavy ? n0_r[k] : o0_r[k];
      end
    end
    if (adv[2]) begin
      x2_r <= x_nxt;
      y2_r <= y_nxt;
      z2_r <= z_nxt;
    end
    if (adv[3]) begin
      s3_r <= SW'(x2_r) + SW'(y2_r);
      d3_r <= SW'(x2_r) - SW'(y2_r);
      t3_r <= SW'(z2_r) <<< 1;
    end
    if (adv[4]) begin
      s4_r <= s3_r;
      md4_r <= d3_r[SW-1] ? MW'(-d3_r) : MW'(d3_r);
      mt4_r <= t3_r[SW-1] ? MW'(-t3_r) : MW'(t3_r);
    end
    if (adv[5]) begin
      s5_r <= s4_r;
      dhh5_r <= PW'(dh) * PW'(dh);
      dhl5_r <= PW'(dh) * PW'(dl);
      dll5_r <= PW'(dl) * PW'(dl);
      thh5_r <= PW'(th) * PW'(th);
      thl5_r <= PW'(th) * PW'(tl);
      tll5_r <= PW'(tl) * PW'(tl);
    end
    if (adv[6]) begin
      s6_r <= s5_r;
      q6_r <= (QW'(dhh5_r) << (2 * LO)) + (QW'(dhl5_r) << (LO + 1)) + QW'(dll5_r)
            + (QW'(thh5_r) << (2 * LO)) + (QW'(thl5_r) << (LO + 1)) + QW'(tll5_r);
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        skip_r[k] <= skip_r[k-1];
        int_r[k] <= int_r[k-1];
      end
    end
  end

endmodule

// File: sv/bmc_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side tag
// that travels alongside. Standalone; no package use.
module bmc_sqrt #(
  parameter int GW = 40,
  parameter int TAGW = 42
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2*GW-2:0]   in_q,
  input  logic [TAGW-1:0]   in_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [GW-1:0]     out_root,
  output logic [TAGW-1:0]   out_tag
);

  localparam int NS = GW;
  localparam int RW = GW + 2;

  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;
  logic [GW-1:0] root_r [NS];
  logic [RW-1:0] rem_r [NS];
  logic [2*GW-1:0] qs_r [NS];
  logic [TAGW-1:0] tag_r [NS];

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];
  assign out_valid = v_r[NS-1];
  assign out_root = root_r[NS-1];
  assign out_tag = tag_r[NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [GW-1:0] root_i;
    logic [RW-1:0] rem_i;
    logic [2*GW-1:0] qs_i;
    logic [TAGW-1:0] tag_i;
    logic vin;
    logic [RW+1:0] part;
    logic [RW+1:0] trial;
    logic fits;

    if (k == 0) begin : g_first
      assign root_i = '0;
      assign rem_i = '0;
      assign qs_i = {1'b0, in_q};
      assign tag_i = in_tag;
      assign vin = in_valid;
    end else begin : g_next
      assign root_i = root_r[k-1];
      assign rem_i = rem_r[k-1];
      assign qs_i = qs_r[k-1];
      assign tag_i = tag_r[k-1];
      assign vin = v_r[k-1];
    end

    always_comb begin
      part = {rem_i, qs_i[2*GW-1:2*GW-2]};
      trial = (RW+2)'({root_i, 2'b01});
      fits = part >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv[k]) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        root_r[k] <= {root_i[GW-2:0], fits};
        rem_r[k] <= fits ? RW'(part - trial) : RW'(part);
        qs_r[k] <= qs_i << 2;
        tag_r[k] <= tag_i;
      end
    end
  end

endmodule

// File: sv/bmc_judge.sv
// Failure judgment: normal and shear stress on the friction plane, the
// Mohr-Coulomb and tensile tests, and the result register. Uses bmc_pkg.
module bmc_judge #(
  parameter int W = bmc_pkg::STRESS_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmc_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [W+7:0]        in_root,
  input  logic [W+9:0]        in_tag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_intact,
  output logic [1:0]          out_kind
);

  localparam int NST = 4;
  localparam int SW = W + 8;
  localparam int GW = W + 8;
  localparam int NW = GW + 19;
  localparam int SHW = GW + 17;
  localparam int FW = NW + 21;
  localparam int RW = ((FW > 71) ? FW : 71) + 1;
  localparam int CW = ((RW > SHW + 33) ? RW : SHW + 33) + 1;
  localparam int TW = ((SW + 2 > 40) ? SW + 2 : 40) + 1;

  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;
  logic [NST-2:0] skip_r;
  logic [NST-2:0] int_r;

  logic signed [SW-1:0] s_in;
  logic signed [NW-1:0] nrm_nxt;
  logic signed [TW-1:0] tlim;
  logic [37:0] coh102;
  logic signed [RW-1:0] coh_term;
  logic signed [CW-1:0] sh32, rr, cmp;
  logic shear_ok;

  logic signed [NW-1:0] nrm0_r;
  logic [SHW-1:0] sh0_r, sh1_r, sh2_r;
  logic signed [TW-1:0] tsum0_r;
  logic signed [FW-1:0] fn1_r;
  logic signed [RW-1:0] rhs2_r;
  logic nneg1_r, npos1_r, tok1_r, nneg2_r, npos2_r, tok2_r;
  logic intact3_r;
  logic [1:0] kind3_r;

  always_comb begin
    adv[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];
  assign out_valid = v_r[NST-1];
  assign out_intact = intact3_r;
  assign out_kind = kind3_r;

  always_comb begin
    s_in = $signed(in_tag[SW-1:0]);
    nrm_nxt = (NW'(s_in) <<< 16)
            - NW'($signed({1'b0, in_root})) * NW'(cfg.plane_cosine);
    tlim = (TW'(cfg.tensile_strength) <<< 6) + (TW'(cfg.tensile_strength) <<< 5)
         + (TW'(cfg.tensile_strength) <<< 2) + (TW'(cfg.tensile_strength) <<< 1);
    coh102 = 38'(cfg.cohesion) * 38'(bmc_pkg::SCALE2);
    coh_term = RW'($signed({1'b0, coh102})) <<< 32;
    sh32 = CW'($signed({1'b0, sh2_r, 16'h0}));
    rr = CW'(rhs2_r);
    cmp = rr[CW-1] ? (sh32 + rr) : (sh32 - rr);
    shear_ok = !cmp[CW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      nrm0_r <= nrm_nxt;
      sh0_r <= SHW'(in_root) * SHW'(cfg.plane_sine);
      tsum0_r <= TW'(s_in) + TW'($signed({1'b0, in_root}));
      skip_r[0] <= in_tag[SW+1];
      int_r[0] <= in_tag[SW];
    end
    if (adv[1]) begin
      fn1_r <= FW'(nrm0_r) * FW'($signed({1'b0, cfg.friction_tangent}));
      sh1_r <= sh0_r;
      nneg1_r <= nrm0_r[NW-1];
      npos1_r <= !nrm0_r[NW-1] && (nrm0_r != '0);
      tok1_r <= tsum0_r >= tlim;
      skip_r[1] <= skip_r[0];
      int_r[1] <= int_r[0];
    end
    if (adv[2]) begin
      rhs2_r <= coh_term - RW'(fn1_r);
      sh2_r <= sh1_r;
      nneg2_r <= nneg1_r;
      npos2_r <= npos1_r;
      tok2_r <= tok1_r;
      skip_r[2] <= skip_r[1];
      int_r[2] <= int_r[1];
    end
    if (adv[3]) begin
      if (skip_r[2]) begin
        intact3_r <= int_r[2];
        kind3_r <= bmc_pkg::FAIL_NONE;
      end else if (nneg2_r && shear_ok) begin
        intact3_r <= 1'b0;
        kind3_r <= bmc_pkg::FAIL_SHEAR;
      end else if (npos2_r && tok2_r) begin
        intact3_r <= 1'b0;
        kind3_r <= bmc_pkg::FAIL_TENSION;
      end else begin
        intact3_r <= 1'b1;
        kind3_r <= bmc_pkg::FAIL_NONE;
      end
    end
  end

endmodule

// File: sv/bond_mohr_coulomb_break_test.sv
// Top level of the bond Mohr-Coulomb break test: stream ports, configuration
// registers and the front, square root and judgment pipelines. Uses bmc_pkg.
//
// Each transaction on the input stream carries one 2D peridynamic bond: the plane
// stresses of both particles, their unbreakable flags and the bond's connected
// flag. The block returns one result transaction per input, in order, with the
// new connected flag and the failure kind. It takes one bond every cycle while
// the output is not stalled. The pipeline holds seven weighting and squaring
// stages, one square root stage per result bit (STRESS_WIDTH + 8), and four
// judgment stages ending in the output register. The user must write
// configuration only while no bond is in flight; the block does not enforce it.
module bond_mohr_coulomb_break_test #(
  parameter int STRESS_WIDTH = bmc_pkg::STRESS_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // own_sxx, own_syy, own_sxy, nbr_sxx, nbr_syy, nbr_sxy, own_locked,
  // nbr_locked, bond_intact, then zero fill.
  input  logic [((6*STRESS_WIDTH+10)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // bond_intact_out, then zero fill.
  output logic [7:0]                        out_tdata,
  // failure_kind.
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int W = STRESS_WIDTH;
  localparam int GW = W + 8;
  localparam int TAGW = W + 10;

  bmc_pkg::cfg_t cfg_r;

  logic f_valid, f_ready;
  logic [2*GW-2:0] f_q;
  logic [TAGW-1:0] f_tag;
  logic r_valid, r_ready;
  logic [GW-1:0] r_root;
  logic [TAGW-1:0] r_tag;
  logic res_intact;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cohesion <= '0;
      cfg_r.tensile_strength <= '0;
      cfg_r.friction_tangent <= '0;
      cfg_r.plane_cosine <= '0;
      cfg_r.plane_sine <= bmc_pkg::PLANE_SIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bmc_pkg::REG_COHESION: cfg_r.cohesion <= cfg_data[30:0];
        bmc_pkg::REG_TENSILE: cfg_r.tensile_strength <= $signed(cfg_data[31:0]);
        bmc_pkg::REG_FRICTION_TAN: cfg_r.friction_tangent <= cfg_data[19:0];
        bmc_pkg::REG_PLANE_COS: cfg_r.plane_cosine <= $signed(cfg_data[16:0]);
        bmc_pkg::REG_PLANE_SIN: cfg_r.plane_sine <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  bmc_front #(.W(W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .own_sxx   ($signed(in_tdata[W-1:0])),
    .own_syy   ($signed(in_tdata[2*W-1:W])),
    .own_sxy   ($signed(in_tdata[3*W-1:2*W])),
    .nbr_sxx   ($signed(in_tdata[4*W-1:3*W])),
    .nbr_syy   ($signed(in_tdata[5*W-1:4*W])),
    .nbr_sxy   ($signed(in_tdata[6*W-1:5*W])),
    .skip      (in_tdata[6*W] || in_tdata[6*W+1] || !in_tdata[6*W+2]),
    .intact    (in_tdata[6*W+2]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_q     (f_q),
    .out_tag   (f_tag)
  );

  bmc_sqrt #(.GW(GW), .TAGW(TAGW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_q      (f_q),
    .in_tag    (f_tag),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_root  (r_root),
    .out_tag   (r_tag)
  );

  bmc_judge #(.W(W)) u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (r_valid),
    .in_ready   (r_ready),
    .in_root    (r_root),
    .in_tag     (r_tag),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_intact (res_intact),
    .out_kind   (out_tuser)
  );

  assign out_tdata = {7'b0, res_intact};

  a_fail_clears_bond: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != bmc_pkg::FAIL_NONE) |-> !out_tdata[0])
    else $error("failed bond still marked connected");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == bmc_pkg::FAIL_NONE) || (out_tuser == bmc_pkg::FAIL_SHEAR)
                   || (out_tuser == bmc_pkg::FAIL_TENSION))
    else $error("illegal failure kind");

  a_backpressure_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while the output is free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

// File: tb/bond_mohr_coulomb_break_test_tb.sv
// Self-checking testbench for bond_mohr_coulomb_break_test: directed table, then random bonds
// over several register settings and stall patterns. Depends on bmc_pkg and the block only.
`timescale 1ns / 1ps

module bond_mohr_coulomb_break_test_tb;

  localparam int SW = 32;
  localparam int IN_W = ((6*SW+10)/8)*8;
  localparam int SETTLE = SW + 40;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [SW-1:0] sxx_o, syy_o, sxy_o, sxx_n, syy_n, sxy_n;
    logic lock_o, lock_n, intact;
  } bond_t;

  typedef struct {
    logic intact;
    logic [1:0] kind;
  } verdict_t;

  typedef struct {
    bond_t b;
    logic known;
    verdict_t v;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready, out_tvalid, out_tready = 0;
  logic [IN_W-1:0] in_tdata = '0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 0, cfg_ready;
  logic [bmc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bmc_pkg::cfg_t regs;
  verdict_t pending_verdicts[$];
  int errors = 0, bonds_sent = 0, verdicts_seen = 0, shear_seen = 0, tension_seen = 0;
  int idle_pct = 0, stall_pct = 0, quiet_cycles = 0;
  bit hold_request = 0;

  bond_mohr_coulomb_break_test dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function automatic verdict_t judge_bond(bond_t b);
    verdict_t v;
    logic signed [63:0] hv[3], lt[3], x, y, z, s, d, t;
    logic signed [127:0] d2, t2, g2, s2, pc2, normal, shear, rhs;
    logic [127:0] q, c;
    logic [63:0] g;
    longint unsigned mo, mn;
    v.intact = b.intact;
    v.kind = bmc_pkg::FAIL_NONE;
    if (b.lock_o || b.lock_n || !b.intact) return v;
    mo = (b.sxx_o < 0 ? -64'(b.sxx_o) : 64'(b.sxx_o)) + (b.syy_o < 0 ? -64'(b.syy_o) : 64'(b.syy_o));
    mn = (b.sxx_n < 0 ? -64'(b.sxx_n) : 64'(b.sxx_n)) + (b.syy_n < 0 ? -64'(b.syy_n) : 64'(b.syy_n));
    if (mo > mn) begin
      hv = '{b.sxx_o, b.syy_o, b.sxy_o};
      lt = '{b.sxx_n, b.syy_n, b.sxy_n};
    end else begin
      hv = '{b.sxx_n, b.syy_n, b.sxy_n};
      lt = '{b.sxx_o, b.syy_o, b.sxy_o};
    end
    x = 64'sd50 * hv[0] + lt[0];
    y = 64'sd50 * hv[1] + lt[1];
    z = 64'sd50 * hv[2] + lt[2];
    s = x + y;
    d = x - y;
    t = 2 * z;
    d2 = d;
    t2 = t;
    q = d2 * d2 + t2 * t2;
    g = '0;
    for (int k = 60; k >= 0; k--) begin
      c = {64'b0, g | (64'd1 << k)};
      if (c * c <= q) g = g | (64'd1 << k);
    end
    g2 = {64'b0, g};
    s2 = s;
    pc2 = regs.plane_cosine;
    normal = (s2 <<< 16) - g2 * pc2;
    shear = (g2 * $signed({111'b0, regs.plane_sine})) <<< 16;
    rhs = ($signed({97'b0, regs.cohesion}) * 102 <<< 32)
          - $signed({108'b0, regs.friction_tangent}) * normal;
    if (rhs < 0) rhs = -rhs;
    if (normal < 0 && shear >= rhs) begin
      v.intact = 0;
      v.kind = bmc_pkg::FAIL_SHEAR;
    end else if (normal > 0 && s2 + g2 >= 102 * $signed(128'(regs.tensile_strength))) begin
      v.intact = 0;
      v.kind = bmc_pkg::FAIL_TENSION;
    end
    return v;
  endfunction

  task automatic write_reg(logic [bmc_pkg::CFG_INDEX_W-1:0] idx,
                           logic [bmc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      bmc_pkg::REG_COHESION: regs.cohesion = val[30:0];
      bmc_pkg::REG_TENSILE: regs.tensile_strength = val;
      bmc_pkg::REG_FRICTION_TAN: regs.friction_tangent = val[19:0];
      bmc_pkg::REG_PLANE_COS: regs.plane_cosine = val[16:0];
      bmc_pkg::REG_PLANE_SIN: regs.plane_sine = val[16:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_bond(bond_t b, logic known, verdict_t v);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {5'b0, b.intact, b.lock_n, b.lock_o, b.sxy_n, b.syy_n, b.sxx_n,
                 b.sxy_o, b.syy_o, b.sxx_o};
    do @(posedge clk); while (!in_tready);
    pending_verdicts.push_back(known ? v : judge_bond(b));
    bonds_sent++;
  endtask

  function automatic logic signed [SW-1:0] rand_stress();
    logic signed [SW-1:0] r;
    r = $urandom;
    case ($urandom_range(5))
      0: r = r >>> $urandom_range(31, 20);
      1: r = r >>> $urandom_range(19, 8);
      2: r = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: r = r >>> $urandom_range(30, 0);
    endcase
    return r;
  endfunction

  function automatic bond_t rand_bond();
    bond_t b;
    b.sxx_o = rand_stress();
    b.syy_o = rand_stress();
    b.sxy_o = rand_stress();
    b.sxx_n = rand_stress();
    b.syy_n = rand_stress();
    b.sxy_n = rand_stress();
    if ($urandom_range(7) == 0) begin
      b.sxx_n = b.sxx_o;
      b.syy_n = b.syy_o;
    end
    b.lock_o = $urandom_range(9) == 0;
    b.lock_n = $urandom_range(9) == 0;
    b.intact = $urandom_range(9) != 0;
    return b;
  endfunction

  always @(posedge clk) begin
    int hold_left;
    if (hold_request && hold_left == 0) hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 0;
      if (hold_left == 0) hold_request = 0;
    end else begin
      out_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_tvalid && out_tready) begin
      verdicts_seen++;
      if (out_tuser == bmc_pkg::FAIL_SHEAR) shear_seen++;
      if (out_tuser == bmc_pkg::FAIL_TENSION) tension_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = pending_verdicts.pop_front();
        if (out_tdata[0] !== e.intact) begin
          $error("bond_intact_out: expected %0d, got %0d", e.intact, out_tdata[0]);
          errors++;
        end
        if (out_tuser !== e.kind) begin
          $error("failure_kind: expected %0d, got %0d", e.kind, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t table_rows[$];
    row_t r;
    bond_t b;
    verdict_t none_v;
    regs = '{cohesion: '0, tensile_strength: '0, friction_tangent: '0, plane_cosine: '0,
             plane_sine: bmc_pkg::PLANE_SIN_RESET};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    b = '{0, 0, 0, 0, 0, 0, 0, 0, 1};
    table_rows.push_back('{b, 1, '{1, bmc_pkg::FAIL_NONE}});
    b = '{32'h7fffffff, 32'h80000000, 5, 1, 2, 3, 1, 0, 1};
    table_rows.push_back('{b, 1, '{1, bmc_pkg::FAIL_NONE}});
    b.lock_o = 0; b.lock_n = 1;
    table_rows.push_back('{b, 1, '{1, bmc_pkg::FAIL_NONE}});
    b.lock_n = 0; b.intact = 0;
    table_rows.push_back('{b, 1, '{0, bmc_pkg::FAIL_NONE}});
    b = '{-32'sd1000, -32'sd1000, 32'sd10, -32'sd1000, -32'sd1000, 0, 1, 1, 0};
    table_rows.push_back('{b, 1, '{0, bmc_pkg::FAIL_NONE}});
    b = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 0, 0, 1};
    table_rows.push_back('{b, 0, none_v});
    b = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
          32'h80000000, 0, 0, 1};
    table_rows.push_back('{b, 0, none_v});
    b = '{1000, -1000, 50000, -1000, 1000, -50000, 0, 0, 1};
    table_rows.push_back('{b, 0, none_v});
    b = '{-500, -500, 90000, 3, 4, 5, 0, 0, 1};
    table_rows.push_back('{b, 0, none_v});
    b = '{70000, 60000, 100, 7, -8, 9, 0, 0, 1};
    table_rows.push_back('{b, 0, none_v});
    b = '{32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 32'h80000000, 0, 0, 1};
    table_rows.push_back('{b, 0, none_v});

    write_reg(bmc_pkg::REG_COHESION, 32'd200);
    write_reg(bmc_pkg::REG_TENSILE, 32'd50000);
    write_reg(bmc_pkg::REG_FRICTION_TAN, 32'd37837);
    write_reg(bmc_pkg::REG_PLANE_COS, -32'sd32768);
    write_reg(bmc_pkg::REG_PLANE_SIN, 32'd56756);
    write_reg(3'd7, 32'hffffffff);
    foreach (table_rows[i]) begin
      r = table_rows[i];
      send_bond(r.b, r.known && (r.b.lock_o || r.b.lock_n || !r.b.intact), r.v);
    end
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_reg(bmc_pkg::REG_COHESION, 32'h7fffffff);
          write_reg(bmc_pkg::REG_TENSILE, 32'h7fffffff);
          write_reg(bmc_pkg::REG_FRICTION_TAN, 32'hfffff);
          write_reg(bmc_pkg::REG_PLANE_COS, -32'sd65536);
          write_reg(bmc_pkg::REG_PLANE_SIN, 32'h1ffff);
        end
        2: begin
          write_reg(bmc_pkg::REG_COHESION, 32'd0);
          write_reg(bmc_pkg::REG_TENSILE, 32'h80000000);
          write_reg(bmc_pkg::REG_FRICTION_TAN, 32'd0);
          write_reg(bmc_pkg::REG_PLANE_COS, 32'd0);
          write_reg(bmc_pkg::REG_PLANE_SIN, 32'd0);
        end
        default: begin
          write_reg(bmc_pkg::REG_COHESION,
                    $urandom_range(1) ? $urandom_range(100000) : $urandom);
          write_reg(bmc_pkg::REG_TENSILE, $urandom >>> $urandom_range(31, 8));
          write_reg(bmc_pkg::REG_FRICTION_TAN, $urandom);
          write_reg(bmc_pkg::REG_PLANE_COS, $urandom);
          write_reg(bmc_pkg::REG_PLANE_SIN, $urandom);
        end
      endcase
      for (int i = 0; i < 130; i++) begin
        if (i % 40 == 0) begin
          case ((phase + i / 40) % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 80; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 80; end
            default: begin idle_pct = 25; stall_pct = 25; end
          endcase
        end
        if (phase == 1 && i == 10) begin
          idle_pct = 0;
          hold_request = 1;
        end
        if (phase == 3 && i == 65) drain();
        send_bond(rand_bond(), 0, none_v);
      end
      drain();
    end

    $display("Covered %0d bonds over 5 register settings; %0d shear and %0d tensile breaks seen.",
             bonds_sent, shear_seen, tension_seen);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
